// ===== sv/multicast_hash_filter_table_top_macros.svh =====
// Assertion macros for the multicast hash filter table.
`ifndef MULTICAST_HASH_FILTER_TABLE_TOP_MACROS_SVH
`define MULTICAST_HASH_FILTER_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define MHFT_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("mhft: forbidden condition seen");

`define MHFT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhft: implication failed");

`define MHFT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhft: next-cycle implication failed");

`else

`define MHFT_ASSERT_NEVER(lbl, clk, rst, cond)
`define MHFT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MHFT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/mhft_pkg.sv =====
`timescale 1ns / 1ps

package mhft_pkg;

  localparam int ADDR_BITS = 48;
  localparam int HASH_W    = 32;
  localparam int INDEX_W   = 6;
  localparam int CNT_W     = $clog2(ADDR_BITS);

  localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [HASH_W-1:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

// ===== sv/mhft_ctrl.sv =====
`timescale 1ns / 1ps

module mhft_ctrl
  import mhft_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    opcode,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == OP_ADD) ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        if (status.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // A new result takes the output register; otherwise it empties once taken.
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== sv/mhft_datapath.sv =====
`timescale 1ns / 1ps

module mhft_datapath
  import mhft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 opcode,
  input  logic [ADDR_BITS-1:0] mc_address,
  output logic [HASH_W-1:0]    addr_hash,
  output logic [INDEX_W-1:0]   bit_index,
  output logic [HASH_W-1:0]    table_low,
  output logic [HASH_W-1:0]    table_high
);

  localparam int NBYTES = ADDR_BITS / 8;

  logic [HASH_W-1:0]    crc;
  logic [ADDR_BITS-1:0] addr_sr;
  logic [CNT_W-1:0]     count;
  logic                 op;
  logic [ADDR_BITS-1:0] addr_swapped;
  logic [HASH_W-1:0]    crc_rev;
  logic [HASH_W-1:0]    hash;
  logic                 fb;

  // Put the first byte at the bottom so that a right shift feeds the bits
  // in wire order: first byte first, each byte least significant bit first.
  always_comb begin
    for (int i = 0; i < NBYTES; i++) begin
      addr_swapped[8*i +: 8] = mc_address[8*(NBYTES-1-i) +: 8];
    end
  end

  always_comb begin
    for (int i = 0; i < HASH_W; i++) begin
      crc_rev[i] = crc[HASH_W-1-i];
    end
  end

  assign fb   = crc[0] ^ addr_sr[0];
  assign hash = (op == OP_ADD) ? crc_rev : '0;

  assign status.last = (count == CNT_W'(ADDR_BITS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      crc     <= CRC_INIT;
      addr_sr <= addr_swapped;
      count   <= '0;
      op      <= opcode;
    end else if (cmd.step) begin
      crc     <= (crc >> 1) ^ (fb ? CRC_POLY : '0);
      addr_sr <= addr_sr >> 1;
      count   <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      addr_hash <= hash;
      bit_index <= hash[HASH_W-1 -: INDEX_W];
    end
  end

  // The table words change only at a commit, which is also when a result
  // enters the output register, so they serve directly as result fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_low  <= '0;
      table_high <= '0;
    end else if (cmd.commit) begin
      if (op == OP_CLEAR) begin
        table_low  <= '0;
        table_high <= '0;
      end else if (hash[HASH_W-1]) begin
        table_high <= table_high | (HASH_W'(1) << hash[HASH_W-2 -: 5]);
      end else begin
        table_low  <= table_low | (HASH_W'(1) << hash[HASH_W-2 -: 5]);
      end
    end
  end

endmodule

// ===== sv/multicast_hash_filter_table_top.sv =====
// An add item's result is registered after 48 CRC steps in the bit-serial CRC
// register and then a commit, which waits until the output register is free. A
// clear item goes straight to the commit. One item is in work at a time; the
// next item is taken the cycle after a commit, even while the last result
// waits, so no item is taken before the one in work is committed.
// Reset (synchronous, active high) clears both table words and the handshakes.
`timescale 1ns / 1ps
`include "multicast_hash_filter_table_top_macros.svh"

module multicast_hash_filter_table_top
  import mhft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 opcode,
  input  logic [ADDR_BITS-1:0] mc_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [HASH_W-1:0]    addr_hash,
  output logic [INDEX_W-1:0]   bit_index,
  output logic [HASH_W-1:0]    table_low,
  output logic [HASH_W-1:0]    table_high
);

  cmd_t    cmd;
  status_t status;

  mhft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mhft_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .opcode     (opcode),
    .mc_address (mc_address),
    .addr_hash  (addr_hash),
    .bit_index  (bit_index),
    .table_low  (table_low),
    .table_high (table_high)
  );

  `MHFT_ASSERT_IMP(a_commit_room, clk, rst, cmd.commit, !out_valid || out_ready)
  `MHFT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `MHFT_ASSERT_NEVER(a_step_while_idle, clk, rst, cmd.step && (in_ready || cmd.commit))

endmodule
